/* hdl/kdf_pkg.sv */
// ----------------------------------------------------------------------------
// kdf_pkg
// Shared types and constants for the keypad debounce and key-code FIFO block.
// ----------------------------------------------------------------------------
package kdf_pkg;

  localparam int unsigned ROWS_DEF       = 4;
  localparam int unsigned COLS_DEF       = 4;
  localparam int unsigned FIFO_DEPTH_DEF = 16;

  localparam int unsigned MAX_COLS  = 8;
  localparam int unsigned ROW_W     = 2;
  localparam int unsigned LVL_W     = 4;
  localparam int unsigned CNT_W     = 8;
  localparam int unsigned CODE_W    = 4;
  localparam int unsigned COUNT_W   = 4;
  localparam int unsigned COL_IDX_W = 3;

  localparam logic [CNT_W-1:0] CNT_MAX      = 8'hFF;
  localparam logic [CNT_W-1:0] STABLE_RESET = 8'd4;

  typedef enum logic {
    MODE_SAMPLE = 1'b0,
    MODE_POP    = 1'b1
  } mode_e;

  typedef struct packed {
    logic             mode;
    logic [ROW_W-1:0] row_index;
    logic [LVL_W-1:0] col_levels;
  } in_t;

  typedef struct packed {
    logic               key_valid;
    logic [CODE_W-1:0]  key_code;
    logic [COUNT_W-1:0] waiting_count;
  } out_t;

  // Classified operation handed from front to back.
  typedef struct packed {
    logic                mode;
    logic [ROW_W-1:0]    row;
    logic [MAX_COLS-1:0] mask;
  } op_t;

endpackage

/* hdl/keypad_debounce_key_fifo.sv */
// ----------------------------------------------------------------------------
// keypad_debounce_key_fifo
// Keypad row-sample debouncer with a ring FIFO of pressed key codes.
// ----------------------------------------------------------------------------
//  channel  signals                          transfer when
//  in       in_valid_i/in_ready_o/in_data_i  in_valid_i && in_ready_o
//  out      out_valid_o/out_ready_i/out_data_o out_valid_o && out_ready_i
//  cfg      cfg_valid_i/cfg_ready_o/cfg_data_i cfg_valid_i && cfg_ready_o
//
//  One item per cycle while neither the queue nor the result stalls; a row
//  sample that reports several presses holds the FIFO write port until each press is pushed or dropped on a full FIFO.
//  An input is registered in the queue and then in the result register.
//  A two-entry queue lets the front keep taking items while the back stalls.
//  Reset clears counters, pointers and sets stable_count to 4; no clear pass.
// ----------------------------------------------------------------------------
module keypad_debounce_key_fifo #(
  parameter int unsigned ROWS       = kdf_pkg::ROWS_DEF,
  parameter int unsigned COLS       = kdf_pkg::COLS_DEF,
  parameter int unsigned FIFO_DEPTH = kdf_pkg::FIFO_DEPTH_DEF
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  kdf_pkg::in_t              in_data_i,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output kdf_pkg::out_t             out_data_o,
  input  logic                      cfg_valid_i,
  output logic                      cfg_ready_o,
  input  logic [kdf_pkg::CNT_W-1:0] cfg_data_i
);

  logic [kdf_pkg::CNT_W-1:0] stable_count_q;
  logic                      op_valid, op_ready, head_valid, deq;
  kdf_pkg::op_t              op, head;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stable_count_q <= kdf_pkg::STABLE_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      stable_count_q <= cfg_data_i;
    end
  end

  kdf_front #(
    .ROWS (ROWS),
    .COLS (COLS)
  ) u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .in_data_i      (in_data_i),
    .stable_count_i (stable_count_q),
    .op_valid_o     (op_valid),
    .op_ready_i     (op_ready),
    .op_o           (op)
  );

  kdf_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .enq_valid_i  (op_valid),
    .enq_ready_o  (op_ready),
    .enq_data_i   (op),
    .head_valid_o (head_valid),
    .head_o       (head),
    .deq_i        (deq)
  );

  kdf_back #(
    .COLS       (COLS),
    .FIFO_DEPTH (FIFO_DEPTH)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_valid_i (head_valid),
    .head_i       (head),
    .deq_o        (deq),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .out_data_o   (out_data_o)
  );

endmodule

/* hdl/kdf_ram.sv */
// ----------------------------------------------------------------------------
// kdf_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module kdf_ram #(
  parameter int unsigned WIDTH = 4,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* hdl/kdf_front.sv */
// ----------------------------------------------------------------------------
// kdf_front
// Accepts items, runs the per-key debounce counters of the sampled row and
// emits a classified operation with the mask of columns that report a press.
// ----------------------------------------------------------------------------
module kdf_front #(
  parameter int unsigned ROWS = kdf_pkg::ROWS_DEF,
  parameter int unsigned COLS = kdf_pkg::COLS_DEF
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  kdf_pkg::in_t               in_data_i,
  input  logic [kdf_pkg::CNT_W-1:0]  stable_count_i,
  output logic                       op_valid_o,
  input  logic                       op_ready_i,
  output kdf_pkg::op_t               op_o
);

  logic [ROWS-1:0][COLS-1:0][kdf_pkg::CNT_W-1:0] cnt_q, cnt_d;
  logic [kdf_pkg::MAX_COLS-1:0]                   lvl;
  logic [kdf_pkg::MAX_COLS-1:0]                   mask;
  logic                                           acc;
  logic                                           sample;

  assign acc        = in_valid_i && op_ready_i;
  assign in_ready_o = op_ready_i;
  assign op_valid_o = in_valid_i;
  assign sample     = (in_data_i.mode == kdf_pkg::MODE_SAMPLE);
  assign lvl = {{(kdf_pkg::MAX_COLS - kdf_pkg::LVL_W){1'b1}}, in_data_i.col_levels};

  always_comb begin
    cnt_d = cnt_q;
    mask  = '0;
    for (int r = 0; r < ROWS; r++) begin
      for (int c = 0; c < COLS; c++) begin
        if (sample && (int'(in_data_i.row_index) == r)) begin
          if (!lvl[c]) begin
            if (cnt_q[r][c] != kdf_pkg::CNT_MAX) begin
              cnt_d[r][c] = cnt_q[r][c] + 8'd1;
              if ((cnt_q[r][c] + 8'd1) == stable_count_i) begin
                mask[c] = 1'b1;
              end
            end
          end else begin
            cnt_d[r][c] = '0;
          end
        end
      end
    end
  end

  assign op_o.mode = in_data_i.mode;
  assign op_o.row  = in_data_i.row_index;
  assign op_o.mask = mask;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (acc) begin
      cnt_q <= cnt_d;
    end
  end

endmodule

/* hdl/kdf_queue.sv */
// ----------------------------------------------------------------------------
// kdf_queue
// Two-entry queue of classified operations between front and back.
// ----------------------------------------------------------------------------
module kdf_queue (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         enq_valid_i,
  output logic         enq_ready_o,
  input  kdf_pkg::op_t enq_data_i,
  output logic         head_valid_o,
  output kdf_pkg::op_t head_o,
  input  logic         deq_i
);

  kdf_pkg::op_t ent_q [2];
  logic         rd_q, wr_q;
  logic [1:0]   cnt_q;
  logic         enq;
  logic         deq;

  assign enq_ready_o  = (cnt_q != 2'd2);
  assign head_valid_o = (cnt_q != 2'd0);
  assign head_o       = ent_q[rd_q];
  assign enq          = enq_valid_i && enq_ready_o;
  assign deq          = deq_i && head_valid_o;

  always_ff @(posedge clk_i) begin
    if (enq) begin
      ent_q[wr_q] <= enq_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_q  <= 1'b0;
      wr_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (enq) begin
        wr_q <= ~wr_q;
      end
      if (deq) begin
        rd_q <= ~rd_q;
      end
      if (enq && !deq) begin
        cnt_q <= cnt_q + 2'd1;
      end else if (deq && !enq) begin
        cnt_q <= cnt_q - 2'd1;
      end
    end
  end

endmodule

/* hdl/kdf_back.sv */
// ----------------------------------------------------------------------------
// kdf_back
// Executes queued operations on the key-code ring FIFO: one push or one pop
// per cycle, stalling while the held result is not taken, and holds the result register.
// ----------------------------------------------------------------------------
module kdf_back #(
  parameter int unsigned COLS       = kdf_pkg::COLS_DEF,
  parameter int unsigned FIFO_DEPTH = kdf_pkg::FIFO_DEPTH_DEF
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         head_valid_i,
  input  kdf_pkg::op_t head_i,
  output logic         deq_o,
  output logic         out_valid_o,
  input  logic         out_ready_i,
  output kdf_pkg::out_t out_data_o
);

  localparam int unsigned PTR_W = $clog2(FIFO_DEPTH);
  localparam int unsigned FILL_W = PTR_W + 1;
  localparam int unsigned SUM_W = 7;

  typedef struct packed {
    logic                        key_valid;
    logic [kdf_pkg::COUNT_W-1:0] waiting_count;
  } res_t;

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    return (p == PTR_W'(FIFO_DEPTH - 1)) ? '0 : p + PTR_W'(1);
  endfunction

  logic [PTR_W-1:0]                 wp_q, wp_d, rp_q, rp_d, wp_nx;
  logic [kdf_pkg::MAX_COLS-1:0]     done_q, done_d, eff, bit_sel, rest;
  logic [kdf_pkg::COL_IDX_W-1:0]    col;
  logic [SUM_W-1:0]                 code_sum;
  logic [FILL_W-1:0]                fill;
  logic [8:0]                       fill_ext;
  logic                             res_valid_q, res_valid_d;
  res_t                             res_q, res_d;
  logic                             out_free, has, last, full;
  logic                             we, re, load, kv;
  logic [kdf_pkg::CODE_W-1:0]       rdata;

  always_comb begin
    col = '0;
    for (int i = kdf_pkg::MAX_COLS - 1; i >= 0; i--) begin
      if (eff[i]) begin
        col = kdf_pkg::COL_IDX_W'(i);
      end
    end
  end

  assign eff      = head_i.mask & ~done_q;
  assign has      = |eff;
  assign bit_sel  = kdf_pkg::MAX_COLS'(1) << col;
  assign rest     = eff & ~bit_sel;
  assign last     = (rest == '0);
  assign wp_nx    = ptr_inc(wp_q);
  assign full     = (wp_nx == rp_q);
  assign out_free = !res_valid_q || out_ready_i;
  assign code_sum = SUM_W'(head_i.row) * SUM_W'(COLS) + SUM_W'(col);

  always_comb begin
    we     = 1'b0;
    re     = 1'b0;
    load   = 1'b0;
    kv     = 1'b0;
    deq_o  = 1'b0;
    wp_d   = wp_q;
    rp_d   = rp_q;
    done_d = done_q;
    if (head_valid_i) begin
      if (head_i.mode == kdf_pkg::MODE_POP) begin
        if (out_free) begin
          load  = 1'b1;
          deq_o = 1'b1;
          if (wp_q != rp_q) begin
            re   = 1'b1;
            kv   = 1'b1;
            rp_d = ptr_inc(rp_q);
          end
        end
      end else if (has && !last) begin
        we     = !full;
        wp_d   = full ? wp_q : wp_nx;
        done_d = done_q | bit_sel;
      end else if (out_free) begin
        if (has) begin
          we   = !full;
          wp_d = full ? wp_q : wp_nx;
        end
        load  = 1'b1;
        deq_o = 1'b1;
      end
    end
    if (deq_o) begin
      done_d = '0;
    end
  end

  assign fill = (wp_d >= rp_d) ? (FILL_W'(wp_d) - FILL_W'(rp_d))
                               : (FILL_W'(wp_d) + FILL_W'(FIFO_DEPTH) - FILL_W'(rp_d));
  assign fill_ext = 9'(fill);

  assign res_d.key_valid     = kv;
  assign res_d.waiting_count = fill_ext[kdf_pkg::COUNT_W-1:0];
  assign res_valid_d = load ? 1'b1 : (out_ready_i ? 1'b0 : res_valid_q);

  kdf_ram #(
    .WIDTH (kdf_pkg::CODE_W),
    .DEPTH (FIFO_DEPTH)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (wp_q),
    .wdata_i (code_sum[kdf_pkg::CODE_W-1:0]),
    .re_i    (re),
    .raddr_i (rp_q),
    .rdata_o (rdata)
  );

  always_ff @(posedge clk_i) begin
    if (load) begin
      res_q <= res_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q        <= '0;
      rp_q        <= '0;
      done_q      <= '0;
      res_valid_q <= 1'b0;
    end else begin
      wp_q        <= wp_d;
      rp_q        <= rp_d;
      done_q      <= done_d;
      res_valid_q <= res_valid_d;
    end
  end

  assign out_valid_o              = res_valid_q;
  assign out_data_o.key_valid     = res_q.key_valid;
  assign out_data_o.key_code      = res_q.key_valid ? rdata : '0;
  assign out_data_o.waiting_count = res_q.waiting_count;

  a_ptr_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (wp_q <= PTR_W'(FIFO_DEPTH - 1)) && (rp_q <= PTR_W'(FIFO_DEPTH - 1)))
    else $error("fifo pointer out of range");

  a_done_subset: assert property (@(posedge clk_i) disable iff (!rst_ni)
    head_valid_i |-> ((done_q & ~head_i.mask) == '0))
    else $error("done mask has columns the head never asked for");

  a_code_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_q && res_q.key_valid && !out_ready_i) |=> $stable(rdata))
    else $error("popped code changed while result stalled");

  a_no_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    we |=> (wp_q != rp_q))
    else $error("push left fifo looking empty");

endmodule
